FILE: hw/rtl/ssd_pkg.sv
// ssd_pkg: shared types and codes for the stepper step/dir controller.
// Holds the command and result word structs and the operation and motion codes.
// No dependencies.
package ssd_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_REVERSE = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_SUSPEND = 3'd4;
    localparam logic [2:0] OP_WAKE    = 3'd5;

    // Motion / direction request codes
    localparam logic [1:0] MOTION_FWD     = 2'd0;
    localparam logic [1:0] MOTION_REV     = 2'd1;
    localparam logic [1:0] MOTION_STOPPED = 2'd2;
    localparam logic [1:0] DIR_INVALID    = 2'd3;

    localparam int unsigned CountW = 32;

    typedef struct packed {
        logic [2:0]        operation;
        logic [1:0]        direction;
        logic [CountW-1:0] step_count;
    } t_in_word;

    typedef struct packed {
        logic              step_level;
        logic              dir_level;
        logic              sleep_level;
        logic              accepted;
        logic [CountW-1:0] steps_left;
        logic [CountW-1:0] steps_taken;
        logic [1:0]        motion_state;
    } t_out_word;

    // Status from the result queue back to the command stage
    typedef struct packed {
        logic room;
        logic full;
    } t_buf_status;

endpackage

FILE: hw/rtl/stepper_step_dir_controller.sv
// stepper_step_dir_controller: top level of the step/dir/sleep pulse generator.
// Instantiates ssd_core and ssd_out_buf; depends on ssd_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one command
//   word: tick, start, reverse, stop, suspend or wake. Output channel
//   (o_out_valid / i_out_stall / o_out_word) returns exactly one result word
//   per command with the pin levels, counters and motion state.
//   A word is accepted on a rising edge where valid is high and stall is low.
// Throughput and data path:
//   One command per cycle while the result queue has room. A command is held in
//   the command register, is executed into the result queue, and appears on the
//   output from the queue's storage register.
// Reset:
//   i_rst_n is synchronous, active low. It clears the counters, pins and
//   queues; the motor comes out of reset awake with nothing to run.
// Receiver stall:
//   Results wait in a two-entry queue; the command stage keeps accepting
//   until that queue is full, then raises o_in_stall until a word drains.
module stepper_step_dir_controller
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic        r_cmd_valid;
    t_in_word    r_cmd;
    logic        exec;
    logic        in_fire;
    t_out_word   result;
    t_buf_status buf_status;
    logic [1:0]  buf_count;

    // Command executes when the result queue has room
    assign exec       = r_cmd_valid && buf_status.room;
    assign o_in_stall = r_cmd_valid && !buf_status.room;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (!r_cmd_valid || exec) begin
            r_cmd_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_word;
        end
    end

    ssd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (exec),
        .i_cmd    (r_cmd),
        .o_result (result)
    );

    ssd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (exec),
        .i_word   (result),
        .o_status (buf_status),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_out_word),
        .o_count  (buf_count)
    );

    // Queue never holds more than two words
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_count != 2'd3)
        else $error("result queue count out of range");

    // Input stalls only while a command waits on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_cmd_valid && buf_status.full))
        else $error("input stall without a blocked command");

    // An accepted word is held in the command register next cycle
    a_cmd_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_cmd_valid)
        else $error("accepted command lost");

    // An executed command always shows a result next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> o_out_valid)
        else $error("executed command produced no result");

endmodule

FILE: hw/rtl/ssd_core.sv
// ssd_core: motor state registers and the per-command update logic.
// Produces one result word per executed command. Depends on ssd_pkg.
module ssd_core
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_exec,
    input  t_in_word  i_cmd,
    output t_out_word o_result
);

    logic [CountW-1:0] r_remaining, n_remaining;
    logic [CountW-1:0] r_taken, n_taken;
    logic [1:0]        r_motion, n_motion;
    logic              r_awake, n_awake;
    logic              r_phase, n_phase;
    logic              r_dir_pin, n_dir_pin;
    logic              r_sleep_pin, n_sleep_pin;
    logic              r_step_pin, n_step_pin;
    logic              n_ok;

    // Next-state logic for one command
    always_comb begin
        n_remaining = r_remaining;
        n_taken     = r_taken;
        n_motion    = r_motion;
        n_awake     = r_awake;
        n_phase     = r_phase;
        n_dir_pin   = r_dir_pin;
        n_sleep_pin = r_sleep_pin;
        n_step_pin  = r_step_pin;
        n_ok        = 1'b1;
        case (i_cmd.operation)
            OP_TICK: begin
                n_step_pin = 1'b0;
                if ((r_remaining != '0) && r_awake) begin
                    if (!r_phase) begin
                        n_remaining = r_remaining - CountW'(1);
                        n_taken     = r_taken + CountW'(1);
                        n_step_pin  = 1'b1;
                        n_phase     = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                    end
                end
            end
            OP_START: begin
                n_remaining = i_cmd.step_count;
                n_taken     = '0;
                n_sleep_pin = 1'b1;
                if (i_cmd.direction != DIR_INVALID) begin
                    n_motion  = i_cmd.direction;
                    n_dir_pin = (i_cmd.direction == MOTION_FWD);
                end else begin
                    n_motion    = MOTION_STOPPED;
                    n_sleep_pin = 1'b0;
                    n_ok        = 1'b0;
                end
            end
            OP_REVERSE: begin
                n_remaining = i_cmd.step_count;
                n_taken     = '0;
                n_sleep_pin = 1'b1;
                case (r_motion)
                    MOTION_FWD: begin
                        n_motion  = MOTION_REV;
                        n_dir_pin = 1'b0;
                    end
                    MOTION_REV: begin
                        n_motion  = MOTION_FWD;
                        n_dir_pin = 1'b1;
                    end
                    default: begin
                        n_motion    = MOTION_STOPPED;
                        n_sleep_pin = 1'b0;
                    end
                endcase
            end
            OP_STOP: begin
                n_motion    = MOTION_STOPPED;
                n_remaining = '0;
                n_sleep_pin = 1'b0;
            end
            OP_SUSPEND: begin
                n_sleep_pin = 1'b1;
                n_awake     = 1'b0;
            end
            OP_WAKE: begin
                if (r_remaining == '0) begin
                    n_sleep_pin = 1'b0;
                end
                n_awake = 1'b1;
            end
            default: begin
                // undefined codes leave everything as is
            end
        endcase
    end

    // Result word reflects the state after the command
    always_comb begin
        o_result.step_level   = n_step_pin;
        o_result.dir_level    = n_dir_pin;
        o_result.sleep_level  = n_sleep_pin;
        o_result.accepted     = n_ok;
        o_result.steps_left   = n_remaining;
        o_result.steps_taken  = n_taken;
        o_result.motion_state = n_motion;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_taken     <= '0;
            r_motion    <= MOTION_FWD;
            r_awake     <= 1'b1;
            r_phase     <= 1'b0;
            r_dir_pin   <= 1'b0;
            r_sleep_pin <= 1'b0;
            r_step_pin  <= 1'b0;
        end else if (i_exec) begin
            r_remaining <= n_remaining;
            r_taken     <= n_taken;
            r_motion    <= n_motion;
            r_awake     <= n_awake;
            r_phase     <= n_phase;
            r_dir_pin   <= n_dir_pin;
            r_sleep_pin <= n_sleep_pin;
            r_step_pin  <= n_step_pin;
        end
    end

endmodule

FILE: hw/rtl/ssd_out_buf.sv
// ssd_out_buf: two-entry result queue that decouples the receiver's stall
// from the command stage. Depends on ssd_pkg.
module ssd_out_buf
    import ssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_out_word   i_word,
    output t_buf_status o_status,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_word,
    output logic [1:0]  o_count
);

    t_out_word  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Room is taken from the registered count only
    assign o_status.room = (r_count != 2'd2);
    assign o_status.full = (r_count == 2'd2);

    always_comb begin
        n_count = r_count;
        case ({i_push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: sim/stepper_step_dir_controller_tb.sv
`timescale 1ns / 1ps
// Testbench for stepper_step_dir_controller: sends command words over the
// valid/stall input channel, predicts every result word and checks the output.
// Depends on ssd_pkg and the controller RTL.
module stepper_step_dir_controller_tb
    import ssd_pkg::*;
();

    // Operation codes the block must ignore
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int IdleLimit   = 4000;
    localparam int DrainCycles = 10;
    localparam int MaxPrinted  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Motor model state
    logic [CountW-1:0] mdl_left;
    logic [CountW-1:0] mdl_taken;
    logic [1:0]        mdl_motion;
    logic              mdl_awake;
    logic              mdl_phase;
    logic              mdl_dir;
    logic              mdl_sleep;
    logic              mdl_step;

    t_out_word pin_report_q[$];
    int        errors        = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles  = 0;

    stepper_step_dir_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic reset_motor_model();
        mdl_left   = '0;
        mdl_taken  = '0;
        mdl_motion = MOTION_FWD;
        mdl_awake  = 1'b1;
        mdl_phase  = 1'b0;
        mdl_dir    = 1'b0;
        mdl_sleep  = 1'b0;
        mdl_step   = 1'b0;
    endtask

    // Apply one command to the motor model and build the pin report it gives
    task automatic advance_motor(input t_in_word cmd, output t_out_word rep);
        logic ok;
        ok = 1'b1;
        case (cmd.operation)
            OP_TICK: begin
                mdl_step = 1'b0;
                if (mdl_left != '0 && mdl_awake) begin
                    if (!mdl_phase) begin
                        mdl_left  = mdl_left - CountW'(1);
                        mdl_taken = mdl_taken + CountW'(1);
                        mdl_step  = 1'b1;
                        mdl_phase = 1'b1;
                    end else begin
                        mdl_phase = 1'b0;
                    end
                end
            end
            OP_START: begin
                mdl_left  = cmd.step_count;
                mdl_taken = '0;
                mdl_sleep = 1'b1;
                if (cmd.direction != DIR_INVALID) begin
                    mdl_motion = cmd.direction;
                    mdl_dir    = (cmd.direction == MOTION_FWD);
                end else begin
                    // bad direction: count still loads, motor parks asleep
                    mdl_motion = MOTION_STOPPED;
                    mdl_sleep  = 1'b0;
                    ok         = 1'b0;
                end
            end
            OP_REVERSE: begin
                mdl_left  = cmd.step_count;
                mdl_taken = '0;
                mdl_sleep = 1'b1;
                case (mdl_motion)
                    MOTION_FWD: begin
                        mdl_motion = MOTION_REV;
                        mdl_dir    = 1'b0;
                    end
                    MOTION_REV: begin
                        mdl_motion = MOTION_FWD;
                        mdl_dir    = 1'b1;
                    end
                    default: begin
                        mdl_motion = MOTION_STOPPED;
                        mdl_sleep  = 1'b0;
                    end
                endcase
            end
            OP_STOP: begin
                mdl_motion = MOTION_STOPPED;
                mdl_left   = '0;
                mdl_sleep  = 1'b0;
            end
            OP_SUSPEND: begin
                mdl_sleep = 1'b1;
                mdl_awake = 1'b0;
            end
            OP_WAKE: begin
                if (mdl_left == '0) mdl_sleep = 1'b0;
                mdl_awake = 1'b1;
            end
            default: ;
        endcase
        rep.step_level   = mdl_step;
        rep.dir_level    = mdl_dir;
        rep.sleep_level  = mdl_sleep;
        rep.accepted     = ok;
        rep.steps_left   = mdl_left;
        rep.steps_taken  = mdl_taken;
        rep.motion_state = mdl_motion;
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MaxPrinted) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [CountW-1:0] got,
                               input logic [CountW-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compare one received word with the oldest pending report
    task automatic check_pin_report(input t_out_word got);
        t_out_word want;
        if (pin_report_q.size() == 0) begin
            report_error("result word with nothing expected");
        end else begin
            want = pin_report_q.pop_front();
            check_field("step_level", CountW'(got.step_level), CountW'(want.step_level));
            check_field("dir_level", CountW'(got.dir_level), CountW'(want.dir_level));
            check_field("sleep_level", CountW'(got.sleep_level),
                        CountW'(want.sleep_level));
            check_field("accepted", CountW'(got.accepted), CountW'(want.accepted));
            check_field("steps_left", got.steps_left, want.steps_left);
            check_field("steps_taken", got.steps_taken, want.steps_taken);
            check_field("motion_state", CountW'(got.motion_state),
                        CountW'(want.motion_state));
        end
    endtask

    // Receiver: take results, stall at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_pin_report(out_word);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: cycles with no word moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word make_cmd(input logic [2:0] op, input logic [1:0] dir,
                                          input logic [CountW-1:0] cnt);
        t_in_word w;
        w.operation  = op;
        w.direction  = dir;
        w.step_count = cnt;
        return w;
    endfunction

    // Send one command word, idling first at random; predict on accept
    task automatic send_command(input t_in_word cmd);
        t_out_word rep;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= cmd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_motor(cmd, rep);
        pin_report_q.push_back(rep);
    endtask

    function automatic logic [CountW-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(0, 12);
        if (r < 95) return $urandom_range(13, 1000);
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_direction();
        int r;
        r = $urandom_range(99);
        if (r < 40) return MOTION_FWD;
        if (r < 80) return MOTION_REV;
        if (r < 90) return MOTION_STOPPED;
        return DIR_INVALID;
    endfunction

    // Commands inside a run: mostly ticks, some interruptions and noise
    function automatic t_in_word pick_run_command();
        int r;
        r = $urandom_range(99);
        if (r < 70) return make_cmd(OP_TICK, 2'($urandom_range(0, 3)), $urandom());
        if (r < 76) return make_cmd(OP_SUSPEND, 2'($urandom_range(0, 3)), $urandom());
        if (r < 84) return make_cmd(OP_WAKE, 2'($urandom_range(0, 3)), $urandom());
        if (r < 89) return make_cmd(OP_REVERSE, 2'($urandom_range(0, 3)), pick_count());
        if (r < 92) return make_cmd(OP_STOP, 2'($urandom_range(0, 3)), $urandom());
        if (r < 95) return make_cmd(OP_START, pick_direction(), pick_count());
        if (r < 98) return make_cmd(r[0] ? OP_RSVD6 : OP_RSVD7, 2'($urandom_range(0, 3)),
                                    $urandom());
        return make_cmd(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom());
    endfunction

    // Tick and wake straight out of reset: nothing to run
    task automatic test_reset_state();
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_WAKE, 2'd0, '0));
    endtask

    // Start with every direction code and the largest count
    task automatic test_start_directions();
        send_command(make_cmd(OP_START, MOTION_FWD, 32'd3));
        repeat (3) send_command(make_cmd(OP_TICK, 2'd3, '1));
        send_command(make_cmd(OP_START, MOTION_REV, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_START, MOTION_STOPPED, 32'd2));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_START, DIR_INVALID, 32'd5));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
    endtask

    // Reverse from forward, from reverse and while stopped
    task automatic test_reverse();
        send_command(make_cmd(OP_START, MOTION_FWD, 32'd1));
        send_command(make_cmd(OP_REVERSE, 2'd0, 32'd0));
        send_command(make_cmd(OP_REVERSE, 2'd3, 32'h8000_0000));
        send_command(make_cmd(OP_STOP, 2'd0, '1));
        send_command(make_cmd(OP_REVERSE, 2'd1, 32'd4));
    endtask

    // Suspend holds the pulse phase; wake with steps left keeps sleep line
    task automatic test_suspend_wake();
        send_command(make_cmd(OP_START, MOTION_REV, 32'd2));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_SUSPEND, 2'd0, '0));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_WAKE, 2'd0, '0));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
        send_command(make_cmd(OP_TICK, 2'd0, '0));
    endtask

    task automatic test_undefined_ops();
        send_command(make_cmd(OP_RSVD6, 2'd2, 32'h5A5A_A5A5));
        send_command(make_cmd(OP_RSVD7, 2'd3, '1));
    endtask

    // Runs: a start, then a burst of ticks with random interruptions
    task automatic test_random_runs(input int n_items);
        int       sent;
        int       burst;
        t_in_word cmd;
        sent = 0;
        while (sent < n_items) begin
            send_command(make_cmd(OP_START, pick_direction(), pick_count()));
            sent++;
            burst = $urandom_range(2, 30);
            repeat (burst) begin
                cmd = pick_run_command();
                send_command(cmd);
                sent++;
            end
        end
    endtask

    initial begin
        reset_motor_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 79;
        test_reset_state();
        test_start_directions();
        test_reverse();
        test_suspend_wake();
        test_undefined_ops();
        test_random_runs(630);

        send_idle_pct = 79;
        recv_idle_pct = 36;
        test_random_runs(630);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_runs(640);
        in_valid <= 1'b0;

        // drain, then watch for stray words
        while (pin_report_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
